[src/vnorm_pkg.sv]
// Shared widths, stage counts and side-band type for the vector normalizer.
package vnorm_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 15;

  localparam int OUT_W      = OUT_FRAC_BITS + 1;
  localparam int SQ_W       = 2 * IN_WIDTH;
  localparam int DIV_STEPS  = 2 * OUT_FRAC_BITS;
  localparam int QUO_W      = DIV_STEPS + 1;
  localparam int ROOT_W     = OUT_FRAC_BITS + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int REM_W      = OUT_FRAC_BITS + 4;

  localparam logic [ROOT_W-1:0] POS_MAX = ROOT_W'((1 << OUT_FRAC_BITS) - 1);

  // Per-item flags that ride along the pipeline
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
  } side_t;

endpackage

[src/vnorm_ifs.sv]
// Valid/ready stream interfaces for input vectors and normalized results.
interface vnorm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vnorm_pkg::IN_WIDTH-1:0] comp_x;
  logic signed [vnorm_pkg::IN_WIDTH-1:0] comp_y;

  modport source (output valid, comp_x, comp_y, input ready);
  modport sink   (input valid, comp_x, comp_y, output ready);
endinterface

interface vnorm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vnorm_pkg::OUT_W-1:0] unit_x;
  logic signed [vnorm_pkg::OUT_W-1:0] unit_y;
  logic                               zero_length;

  modport source (output valid, unit_x, unit_y, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, zero_length, output ready);
endinterface

[src/vnorm_square.sv]
// Front end: component magnitudes, squares and squared length (3 stages).
module vnorm_square (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic signed [vnorm_pkg::IN_WIDTH-1:0] comp_x,
  input  logic signed [vnorm_pkg::IN_WIDTH-1:0] comp_y,
  output logic                                 out_valid,
  output vnorm_pkg::side_t                     out_side,
  output logic [vnorm_pkg::SQ_W-1:0]           num_x,
  output logic [vnorm_pkg::SQ_W-1:0]           num_y,
  output logic [vnorm_pkg::SQ_W-1:0]           den
);

  logic                            vld_a, vld_b;
  vnorm_pkg::side_t                side_a, side_b;
  logic [vnorm_pkg::IN_WIDTH-1:0]  mag_x, mag_y;
  logic [vnorm_pkg::SQ_W-1:0]      sq_x, sq_y;
  vnorm_pkg::side_t                side_in;
  logic [vnorm_pkg::IN_WIDTH-1:0]  mag_x_next, mag_y_next;

  // Sign and magnitude; the most negative value maps to 2^(W-1) exactly
  always_comb begin
    side_in.neg_x = comp_x[vnorm_pkg::IN_WIDTH-1];
    side_in.neg_y = comp_y[vnorm_pkg::IN_WIDTH-1];
    side_in.zero  = (comp_x == '0) && (comp_y == '0);
    mag_x_next    = side_in.neg_x ? vnorm_pkg::IN_WIDTH'(-comp_x) : comp_x;
    mag_y_next    = side_in.neg_y ? vnorm_pkg::IN_WIDTH'(-comp_y) : comp_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      out_valid <= vld_b;
    end
  end

  // Payload: magnitudes, then squares, then sum
  always_ff @(posedge clk) begin
    if (adv) begin
      side_a   <= side_in;
      mag_x    <= mag_x_next;
      mag_y    <= mag_y_next;
      side_b   <= side_a;
      sq_x     <= vnorm_pkg::SQ_W'(mag_x) * vnorm_pkg::SQ_W'(mag_x);
      sq_y     <= vnorm_pkg::SQ_W'(mag_y) * vnorm_pkg::SQ_W'(mag_y);
      out_side <= side_b;
      num_x    <= sq_x;
      num_y    <= sq_y;
      den      <= sq_x + sq_y;
    end
  end

endmodule

[src/vnorm_div.sv]
// Pipelined restoring divider: floor(num * 2^(2F) / den), one quotient bit a stage.
module vnorm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  vnorm_pkg::side_t            in_side,
  input  logic [vnorm_pkg::SQ_W-1:0]  num_x,
  input  logic [vnorm_pkg::SQ_W-1:0]  num_y,
  input  logic [vnorm_pkg::SQ_W-1:0]  den,
  output logic                        out_valid,
  output vnorm_pkg::side_t            out_side,
  output logic [vnorm_pkg::QUO_W-1:0] quo_x,
  output logic [vnorm_pkg::QUO_W-1:0] quo_y
);

  localparam int N = vnorm_pkg::DIV_STEPS + 1;

  logic                        vld  [N];
  vnorm_pkg::side_t            side [N];
  logic [vnorm_pkg::SQ_W-1:0]  dv   [N];
  logic [vnorm_pkg::SQ_W-1:0]  rx   [N];
  logic [vnorm_pkg::SQ_W-1:0]  ry   [N];
  logic [vnorm_pkg::QUO_W-1:0] qx   [N];
  logic [vnorm_pkg::QUO_W-1:0] qy   [N];

  // Integer bit: num never exceeds den, so it is set only on equality
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= in_side;
      dv[0]   <= den;
      qx[0]   <= vnorm_pkg::QUO_W'(num_x == den);
      qy[0]   <= vnorm_pkg::QUO_W'(num_y == den);
      rx[0]   <= (num_x == den) ? '0 : num_x;
      ry[0]   <= (num_y == den) ? '0 : num_y;
    end
  end

  // Fraction bits
  for (genvar k = 1; k < N; k++) begin : g_step
    logic [vnorm_pkg::SQ_W:0] tx, ty;
    logic                     gx, gy;

    always_comb begin
      tx = {rx[k-1], 1'b0};
      ty = {ry[k-1], 1'b0};
      gx = tx >= {1'b0, dv[k-1]};
      gy = ty >= {1'b0, dv[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[k] <= side[k-1];
        dv[k]   <= dv[k-1];
        rx[k]   <= gx ? vnorm_pkg::SQ_W'(tx - {1'b0, dv[k-1]}) : vnorm_pkg::SQ_W'(tx);
        ry[k]   <= gy ? vnorm_pkg::SQ_W'(ty - {1'b0, dv[k-1]}) : vnorm_pkg::SQ_W'(ty);
        qx[k]   <= {qx[k-1][vnorm_pkg::QUO_W-2:0], gx};
        qy[k]   <= {qy[k-1][vnorm_pkg::QUO_W-2:0], gy};
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_side  = side[N-1];
  assign quo_x     = qx[N-1];
  assign quo_y     = qy[N-1];

endmodule

[src/vnorm_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit a stage, two lanes.
module vnorm_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  vnorm_pkg::side_t             in_side,
  input  logic [vnorm_pkg::QUO_W-1:0]  rad_x,
  input  logic [vnorm_pkg::QUO_W-1:0]  rad_y,
  output logic                         out_valid,
  output vnorm_pkg::side_t             out_side,
  output logic [vnorm_pkg::ROOT_W-1:0] root_x,
  output logic [vnorm_pkg::ROOT_W-1:0] root_y
);

  localparam int N = vnorm_pkg::SQRT_STEPS;

  logic                         vld  [N];
  vnorm_pkg::side_t             side [N];
  logic [vnorm_pkg::RAD_W-1:0]  nx   [N];
  logic [vnorm_pkg::RAD_W-1:0]  ny   [N];
  logic [vnorm_pkg::REM_W-1:0]  rx   [N];
  logic [vnorm_pkg::REM_W-1:0]  ry   [N];
  logic [vnorm_pkg::ROOT_W-1:0] ox   [N];
  logic [vnorm_pkg::ROOT_W-1:0] oy   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                         c_vld;
    vnorm_pkg::side_t             c_side;
    logic [vnorm_pkg::RAD_W-1:0]  c_nx, c_ny;
    logic [vnorm_pkg::REM_W-1:0]  c_rx, c_ry, tx, ty, trx, try_;
    logic [vnorm_pkg::ROOT_W-1:0] c_ox, c_oy;
    logic                         gx, gy;

    // Stage source: ports for the first step, previous stage otherwise
    if (k == 0) begin : g_first
      assign c_vld  = in_valid;
      assign c_side = in_side;
      assign c_nx   = vnorm_pkg::RAD_W'(rad_x);
      assign c_ny   = vnorm_pkg::RAD_W'(rad_y);
      assign c_rx   = '0;
      assign c_ry   = '0;
      assign c_ox   = '0;
      assign c_oy   = '0;
    end else begin : g_next
      assign c_vld  = vld[k-1];
      assign c_side = side[k-1];
      assign c_nx   = nx[k-1];
      assign c_ny   = ny[k-1];
      assign c_rx   = rx[k-1];
      assign c_ry   = ry[k-1];
      assign c_ox   = ox[k-1];
      assign c_oy   = oy[k-1];
    end

    // Bring down two radicand bits, try root*4+1
    always_comb begin
      tx   = {c_rx[vnorm_pkg::REM_W-3:0], c_nx[vnorm_pkg::RAD_W-1 -: 2]};
      ty   = {c_ry[vnorm_pkg::REM_W-3:0], c_ny[vnorm_pkg::RAD_W-1 -: 2]};
      trx  = vnorm_pkg::REM_W'({c_ox, 2'b01});
      try_ = vnorm_pkg::REM_W'({c_oy, 2'b01});
      gx   = tx >= trx;
      gy   = ty >= try_;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[k] <= c_side;
        nx[k]   <= c_nx << 2;
        ny[k]   <= c_ny << 2;
        rx[k]   <= gx ? tx - trx : tx;
        ry[k]   <= gy ? ty - try_ : ty;
        ox[k]   <= {c_ox[vnorm_pkg::ROOT_W-2:0], gx};
        oy[k]   <= {c_oy[vnorm_pkg::ROOT_W-2:0], gy};
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_side  = side[N-1];
  assign root_x    = ox[N-1];
  assign root_y    = oy[N-1];

endmodule

[src/vector2_normalize_unit.sv]
// Stages from input beat to output beat: 3 square, 31 divide, 16 square root,
// 1 output register.
// Throughput: one vector per cycle; the whole pipeline advances together
// and holds while the output register is full and not taken.
// Reset (rst, synchronous) clears all stage valid bits; no clearing pass.
module vector2_normalize_unit (
  input logic        clk,
  input logic        rst,
  vnorm_in_if.sink   in_ch,
  vnorm_out_if.source out_ch
);

  logic                         adv;
  logic                         sq_vld, dv_vld, rt_vld;
  vnorm_pkg::side_t             sq_side, dv_side, rt_side;
  logic [vnorm_pkg::SQ_W-1:0]   num_x, num_y, den;
  logic [vnorm_pkg::QUO_W-1:0]  quo_x, quo_y;
  logic [vnorm_pkg::ROOT_W-1:0] root_x, root_y;
  logic [vnorm_pkg::OUT_W-1:0]  res_x, res_y;

  // Pipeline moves whenever the output register is free or being drained
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  vnorm_square u_square (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .comp_x    (in_ch.comp_x),
    .comp_y    (in_ch.comp_y),
    .out_valid (sq_vld),
    .out_side  (sq_side),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den)
  );

  vnorm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_vld),
    .in_side   (sq_side),
    .num_x     (num_x),
    .num_y     (num_y),
    .den       (den),
    .out_valid (dv_vld),
    .out_side  (dv_side),
    .quo_x     (quo_x),
    .quo_y     (quo_y)
  );

  vnorm_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dv_vld),
    .in_side   (dv_side),
    .rad_x     (quo_x),
    .rad_y     (quo_y),
    .out_valid (rt_vld),
    .out_side  (rt_side),
    .root_x    (root_x),
    .root_y    (root_y)
  );

  // Sign restore, +1.0 saturation, zero vector forced to zero
  always_comb begin
    if (rt_side.zero) begin
      res_x = '0;
    end else if (rt_side.neg_x) begin
      res_x = vnorm_pkg::OUT_W'(-root_x);
    end else begin
      res_x = (root_x > vnorm_pkg::POS_MAX) ? vnorm_pkg::POS_MAX : root_x;
    end
    if (rt_side.zero) begin
      res_y = '0;
    end else if (rt_side.neg_y) begin
      res_y = vnorm_pkg::OUT_W'(-root_y);
    end else begin
      res_y = (root_y > vnorm_pkg::POS_MAX) ? vnorm_pkg::POS_MAX : root_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.unit_x      <= res_x;
      out_ch.unit_y      <= res_y;
      out_ch.zero_length <= rt_side.zero;
    end
  end

endmodule
